// File: hdl/hlva_pkg.sv
// Package: shared constants, job types and the sine/cosine tables of the Hough accumulator.
`default_nettype none

package hlva_pkg;

    localparam int IMAGE_DIM   = 256;
    localparam int DIST_BINS   = 1024;
    localparam int ANGLE_STEPS = 180;

    localparam int ROW_W   = 8;
    localparam int VAL_W   = 16;
    localparam int ANG_W   = $clog2(ANGLE_STEPS);
    localparam int BIN_W   = $clog2(DIST_BINS);
    localparam int OFF_W   = 9;
    localparam int CNT_W   = 17;
    localparam int TRIG_W  = 17;
    localparam int Q_FRAC  = 15;
    localparam int SER_FRAC = 28;

    localparam int STORE_DEPTH = ANGLE_STEPS * DIST_BINS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [CNT_W-1:0] MIN_RESET = CNT_W'(100);
    localparam logic [OFF_W-1:0] OFFSET_RESET = OFF_W'(362);

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 56;

    localparam logic [1:0] JOB_NOP  = 2'd0;
    localparam logic [1:0] JOB_VOTE = 2'd1;
    localparam logic [1:0] JOB_READ = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  col;
        logic [ADDR_W-1:0] raddr;
    } t_job;

    typedef struct packed {
        logic [CNT_W-1:0] max_count;
        logic [CNT_W-1:0] min_count;
        logic [CNT_W-1:0] cell_count;
    } t_result;

    typedef logic signed [TRIG_W-1:0] t_trig;
    typedef logic [ANGLE_STEPS-1:0][TRIG_W-1:0] t_trig_rom;

    // restoring long division, used only while building the tables
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Q15 sine (odd) or cosine table of d*3.14159/180, from a Q28 Taylor series
    function automatic t_trig_rom build_trig_rom(input bit odd);
        t_trig_rom         rom;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint unsigned   n;
        longint unsigned   mag;
        longint unsigned   q;
        longint            sum;
        bit                neg;
        for (int d = 0; d < ANGLE_STEPS; d++) begin
            x = ((longint'(d) * 64'd314159) << SER_FRAC) + 64'd9000000;
            x = udiv64(x, 64'd18000000);
            x2 = (x * x) >> SER_FRAC;
            term = odd ? x : (64'd1 << SER_FRAC);
            n = odd ? 64'd1 : 64'd0;
            sum = 0;
            for (int k = 0; k < 20; k++) begin
                if (k[0]) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
                term = udiv64((term * x2) >> SER_FRAC, (n + 64'd1) * (n + 64'd2));
                n = n + 64'd2;
            end
            neg = (sum < 0);
            mag = neg ? longint'(-sum) : longint'(sum);
            q = (mag + (64'd1 << (SER_FRAC - 16))) >> (SER_FRAC - Q_FRAC);
            rom[d] = neg ? -TRIG_W'(q) : TRIG_W'(q);
        end
        return rom;
    endfunction

    localparam t_trig_rom SIN_ROM = build_trig_rom(1'b1);
    localparam t_trig_rom COS_ROM = build_trig_rom(1'b0);

endpackage

`default_nettype wire

// File: hdl/hlva_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module hlva_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hdl/hlva_front.sv
// Front end: accepts items, classifies them into jobs and queues them for the back end.
`default_nettype none

module hlva_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [hlva_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  wire logic                                s_axis_tuser,
    output hlva_pkg::t_job                           o_job,
    output logic                                     o_job_vld,
    input  wire logic                                i_job_rdy
);

    import hlva_pkg::*;

    logic [ROW_W-1:0]  pix_row;
    logic [ROW_W-1:0]  pix_col;
    logic [VAL_W-1:0]  pix_val;
    logic [ANG_W-1:0]  rd_ang;
    logic [BIN_W-1:0]  rd_bin;
    t_job              job_in;

    t_job              r_q [2];
    logic              r_wr;
    logic              r_rd;
    logic [1:0]        r_cnt;
    logic              push;
    logic              pop;

    assign pix_row = s_axis_tdata[7:0];
    assign pix_col = s_axis_tdata[15:8];
    assign pix_val = s_axis_tdata[31:16];
    assign rd_ang  = s_axis_tdata[39:32];
    assign rd_bin  = s_axis_tdata[49:40];

    always_comb begin
        job_in.row   = pix_row;
        job_in.col   = pix_col;
        job_in.raddr = ADDR_W'(rd_ang) * ADDR_W'(DIST_BINS) + ADDR_W'(rd_bin);
        job_in.kind  = JOB_NOP;
        if (!s_axis_tuser) begin
            if (pix_val != '0 && 32'(pix_row) < IMAGE_DIM && 32'(pix_col) < IMAGE_DIM) begin
                job_in.kind = JOB_VOTE;
            end
        end else if (32'(rd_ang) < ANGLE_STEPS && 32'(rd_bin) < DIST_BINS) begin
            job_in.kind = JOB_READ;
        end
    end

    assign s_axis_tready = i_rst_n && (r_cnt != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign o_job_vld     = (r_cnt != 2'd0);
    assign pop           = o_job_vld && i_job_rdy;
    assign o_job         = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= job_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/hlva_back.sv
// Back end: clearing pass, per-angle vote pipeline with read-modify-write, cell reads, results.
`default_nettype none

module hlva_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire hlva_pkg::t_job                  i_job,
    input  wire logic                            i_job_vld,
    output logic                                 o_job_rdy,
    input  wire logic [hlva_pkg::OFF_W-1:0]      i_dist_off,
    output hlva_pkg::t_result                    o_result,
    output logic                                 o_res_vld,
    input  wire logic                            i_res_rdy
);

    import hlva_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_VOTE  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;
    localparam logic [2:0] ST_RDATA = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    localparam int PROD_W = ROW_W + 1 + TRIG_W;
    localparam int V_W    = PROD_W + 1;
    localparam int DIST_W = V_W - Q_FRAC;
    localparam int TRUNC_ADJ = (1 << Q_FRAC) - 1;

    logic [2:0]              r_state, n_state;
    logic [ADDR_W-1:0]       r_clr, n_clr;
    logic [ANG_W-1:0]        r_ang, n_ang;
    t_job                    r_job;
    logic [CNT_W-1:0]        r_cell;
    logic [CNT_W-1:0]        r_min;
    logic [CNT_W-1:0]        r_max;
    t_result                 r_out;
    logic                    r_out_vld;
    logic                    issue;
    logic                    take;
    logic                    load_out;

    // vote pipeline
    logic                    r_p1_vld, r_p2_vld, r_p3_vld, r_p4_vld, r_p5_vld;
    logic [ANG_W-1:0]        r_p1_ang, r_p2_ang, r_p3_ang, r_p4_ang;
    t_trig                   r_p1_sin, r_p1_cos;
    logic signed [PROD_W-1:0] r_p2_ps, r_p2_pc;
    logic signed [V_W-1:0]   r_p3_v;
    logic [BIN_W-1:0]        r_p4_bin;
    logic [ADDR_W-1:0]       r_p5_addr;

    logic signed [V_W-1:0]   v_adj;
    logic signed [DIST_W-1:0] dist_val;
    logic signed [DIST_W:0]  bin_s;
    logic                    in_range;

    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [CNT_W-1:0]        ram_wdata;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [CNT_W-1:0]        ram_rdata;
    logic [CNT_W-1:0]        cnt_inc;
    logic                    pipe_busy;

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_ang    = r_ang;
        issue    = 1'b0;
        take     = 1'b0;
        load_out = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + ADDR_W'(1);
                if (r_clr == ADDR_W'(STORE_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_job_vld) begin
                    take = 1'b1;
                    n_ang = '0;
                    case (i_job.kind)
                        JOB_VOTE: n_state = ST_VOTE;
                        JOB_READ: n_state = ST_READ;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_VOTE: begin
                issue = 1'b1;
                n_ang = r_ang + ANG_W'(1);
                if (r_ang == ANG_W'(ANGLE_STEPS - 1)) begin
                    n_ang   = '0;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!pipe_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_READ:  n_state = ST_RDATA;
            ST_RDATA: n_state = ST_DONE;
            ST_DONE: begin
                if (!r_out_vld || i_res_rdy) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_job_rdy = (r_state == ST_IDLE);
    assign pipe_busy = r_p1_vld || r_p2_vld || r_p3_vld || r_p4_vld || r_p5_vld;

    // truncation toward zero of the Q15 distance
    always_comb begin
        v_adj    = r_p3_v + (r_p3_v[V_W-1] ? V_W'(TRUNC_ADJ) : V_W'(0));
        dist_val = $signed(v_adj[V_W-1:Q_FRAC]);
        bin_s    = (DIST_W+1)'(dist_val) + $signed((DIST_W+1)'(i_dist_off));
        in_range = !bin_s[DIST_W] && (bin_s < (DIST_W+1)'(DIST_BINS));
    end

    assign cnt_inc   = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + CNT_W'(1);
    assign ram_raddr = (r_state == ST_READ) ? r_job.raddr
                     : ADDR_W'(r_p4_ang) * ADDR_W'(DIST_BINS) + ADDR_W'(r_p4_bin);
    assign ram_we    = (r_state == ST_CLEAR) || r_p5_vld;
    assign ram_waddr = (r_state == ST_CLEAR) ? r_clr : r_p5_addr;
    assign ram_wdata = (r_state == ST_CLEAR) ? '0 : cnt_inc;

    hlva_ram #(
        .WIDTH (CNT_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_job  <= i_job;
            r_cell <= '0;
        end else if (r_state == ST_RDATA) begin
            r_cell <= ram_rdata;
        end
        r_p1_ang  <= r_ang;
        r_p1_sin  <= $signed(SIN_ROM[r_ang]);
        r_p1_cos  <= $signed(COS_ROM[r_ang]);
        r_p2_ang  <= r_p1_ang;
        r_p2_ps   <= PROD_W'($signed({1'b0, r_job.row})) * PROD_W'(r_p1_sin);
        r_p2_pc   <= PROD_W'($signed({1'b0, r_job.col})) * PROD_W'(r_p1_cos);
        r_p3_ang  <= r_p2_ang;
        r_p3_v    <= V_W'(r_p2_ps) - V_W'(r_p2_pc);
        r_p4_ang  <= r_p3_ang;
        r_p4_bin  <= bin_s[BIN_W-1:0];
        r_p5_addr <= ram_raddr;
        if (load_out) begin
            r_out.cell_count <= r_cell;
            r_out.min_count  <= r_min;
            r_out.max_count  <= r_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_ang     <= '0;
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_p3_vld  <= 1'b0;
            r_p4_vld  <= 1'b0;
            r_p5_vld  <= 1'b0;
            r_min     <= MIN_RESET;
            r_max     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ang    <= n_ang;
            r_p1_vld <= issue;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
            r_p4_vld <= r_p3_vld && in_range;
            r_p5_vld <= r_p4_vld;
            if (r_p5_vld) begin
                if (cnt_inc > r_max) begin
                    r_max <= cnt_inc;
                end
                if (cnt_inc < r_min) begin
                    r_min <= cnt_inc;
                end
            end
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_res_rdy) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_result  = r_out;
    assign o_res_vld = r_out_vld;

endmodule

`default_nettype wire

// File: hdl/hough_line_vote_accumulator.sv
// Hough line accumulator over 180 one-degree angles, with stream ports and one offset register.
// After reset a clearing pass zeroes the 184320-cell vote store, one cell per cycle, and the
// first item is taken into work only once it ends (two items queue meanwhile). A vote item with
// a nonzero pixel runs one read-modify-write of the store per in-range angle over 180 angles,
// then a lookup/multiply/address pipeline drain and the result load. Every item returns
// exactly one result.
// distance_offset must only be written while no item is in flight.
`default_nettype none

module hough_line_vote_accumulator (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [hlva_pkg::OFF_W-1:0]       i_cfg_wdata,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // pixel_row[7:0], pixel_col[15:8], pixel_value[31:16], read_angle[39:32],
    // read_bin[49:40], zero pad
    input  wire logic [hlva_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // operation
    input  wire logic                             s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // cell_count[16:0], min_count[33:17], max_count[50:34], zero pad
    output logic [hlva_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

    import hlva_pkg::*;

    logic [OFF_W-1:0] r_dist_off;
    t_job             job;
    logic             job_vld;
    logic             job_rdy;
    t_result          result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_off <= OFFSET_RESET;
        end else if (i_cfg_we) begin
            r_dist_off <= i_cfg_wdata;
        end
    end

    hlva_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_job         (job),
        .o_job_vld     (job_vld),
        .i_job_rdy     (job_rdy)
    );

    hlva_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (job),
        .i_job_vld  (job_vld),
        .o_job_rdy  (job_rdy),
        .i_dist_off (r_dist_off),
        .o_result   (result),
        .o_res_vld  (m_axis_tvalid),
        .i_res_rdy  (m_axis_tready)
    );

    assign m_axis_tdata = {(OUT_DATA_W - 3 * CNT_W)'(0), result};

`ifndef ASSERT_OFF
    a_min_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (result.min_count <= MIN_RESET))
        else $error("running minimum above its start value");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (result.max_count == '0 || result.min_count <= result.max_count))
        else $error("running minimum above running maximum after a vote");

    a_cell_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (result.cell_count <= result.max_count))
        else $error("cell count above running maximum");
`endif

endmodule

`default_nettype wire
